>>> sv/lcgrl_pkg.sv
// Shared types, constants and register codes for the LCG repeat length finder.
package lcgrl_pkg;

  // Field and port widths
  localparam int SEED_W     = 16;
  localparam int LEN_W      = 15;
  localparam int MULT_W     = 16;
  localparam int INCR_W     = 16;
  localparam int MOD_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Default depth of the visited map, the largest usable modulus
  localparam int MODULUS_MAX_DEFAULT = 16384;

  // Register reset values
  localparam logic [MULT_W-1:0] MULT_RESET = 16'd2061;
  localparam logic [INCR_W-1:0] INCR_RESET = 16'd4231;
  localparam logic [MOD_W-1:0]  MOD_RESET  = 15'd10000;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd2;

  // Operation select for the shared modular step unit
  typedef struct packed {
    logic dbl;  // double the accumulator (mod m) first
    logic add;  // then add the addend (mod m)
  } lcgrl_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RED_A,
    ST_RED_C,
    ST_MUL,
    ST_ADD,
    ST_CHECK,
    ST_FINISH
  } lcgrl_state_t;

endpackage

>>> sv/lcgrl_ifs.sv
// Valid/ready channel interfaces for seeds, results and configuration writes.
interface lcgrl_seed_if;
  logic                          valid;
  logic                          ready;
  logic [lcgrl_pkg::SEED_W-1:0]  seed;
  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

interface lcgrl_len_if;
  logic                          valid;
  logic                          ready;
  logic [lcgrl_pkg::LEN_W-1:0]   repeat_length;
  modport source (output valid, output repeat_length, input ready);
  modport sink   (input valid, input repeat_length, output ready);
endinterface

interface lcgrl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lcgrl_pkg::CFG_IDX_W-1:0]   index;
  logic [lcgrl_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/lcgrl_modstep.sv
// Shared modular step unit: acc -> ((dbl ? 2*acc : acc) + addend) mod m.
module lcgrl_modstep #(
  parameter int VW = 14
) (
  input  logic [VW-1:0]         acc,
  input  logic [VW-1:0]         addend,
  input  logic [VW:0]           m,
  input  lcgrl_pkg::lcgrl_op_t  op,
  output logic [VW-1:0]         res
);

  logic [VW:0] dbl_v;
  logic [VW:0] dbl_red;
  logic [VW:0] base;
  logic [VW:0] sum;

  // Double and reduce once; acc < m keeps 2*acc below 2m
  always_comb begin
    dbl_v   = {acc, 1'b0};
    dbl_red = (dbl_v >= m) ? (dbl_v - m) : dbl_v;
    base    = op.dbl ? dbl_red : {1'b0, acc};
  end

  // Add and reduce once; base < m and addend <= m keep the sum below 2m
  always_comb begin
    sum = base + (op.add ? {1'b0, addend} : '0);
    res = (sum >= m) ? VW'(sum - m) : VW'(sum);
  end

endmodule

>>> sv/lcg_repeat_length_finder.sv
// Top level: LCG repeat length finder with visited map and modular step sequencer.
//
// Channels: "item" takes a 16-bit seed, "result" returns the 15-bit repeat
// length, the number of distinct values x = (a*x + c) mod m yields from the
// seed (first value f(seed)) before one repeats. "cfg" writes multiplier (0),
// increment (1) and modulus (2); it is always ready. Write it only while the
// block is idle; the block itself does not enforce this. A modulus of zero
// acts as one, one above MODULUS_MAX saturates to it.
// Per item the block first clears the visited map, one entry a cycle, then
// reduces a and c mod m and forms f(seed) with a bit-serial shift-add modular
// multiply, one operand bit a cycle through one shared double/add/reduce unit.
// Each generated value then takes a multiply pass, an add step and a map check.
// One item is in work at a time; item.ready is high only in the idle state.
// The result sits in an output register; while the receiver stalls, the next
// item may be taken and worked, and holds only at its own finish.
// Reset (rst, synchronous) restores the register defaults and empties the
// block; the map needs no clearing pass after reset.
module lcg_repeat_length_finder #(
  parameter int MODULUS_MAX = lcgrl_pkg::MODULUS_MAX_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  lcgrl_seed_if.sink         item,
  lcgrl_len_if.source        result,
  lcgrl_cfg_if.sink          cfg
);

  localparam int VW = $clog2(MODULUS_MAX);
  localparam int CW = $clog2(MODULUS_MAX + 1);
  localparam int OW = (VW > lcgrl_pkg::SEED_W) ? VW : lcgrl_pkg::SEED_W;
  localparam int BW = $clog2(OW);
  localparam int LW = lcgrl_pkg::LEN_W;

  // Configuration registers
  logic [lcgrl_pkg::MULT_W-1:0] multiplier;
  logic [lcgrl_pkg::INCR_W-1:0] increment;
  logic [lcgrl_pkg::MOD_W-1:0]  modulus;

  // Sequencer and datapath
  lcgrl_pkg::lcgrl_state_t state, state_next;
  logic [lcgrl_pkg::SEED_W-1:0] seed_reg;
  logic [VW-1:0] clr_cnt;
  logic [BW-1:0] bit_cnt;
  logic [OW-1:0] opnd;
  logic [VW-1:0] acc;
  logic [VW-1:0] a_red;
  logic [VW-1:0] c_red;
  logic [CW-1:0] count;
  logic [VW:0]   m_eff;
  logic          clr_last;
  logic          bit_last;
  logic          out_valid;
  logic [LW-1:0] out_len;
  logic          out_free;

  // Shared unit
  lcgrl_pkg::lcgrl_op_t unit_op;
  logic [VW-1:0] unit_addend;
  logic [VW-1:0] unit_res;

  // Visited map
  logic          map_mem [MODULUS_MAX];
  logic          map_we;
  logic [VW-1:0] map_waddr;
  logic          map_wdata;
  logic          map_rd;

  assign cfg.ready     = 1'b1;
  assign result.valid  = out_valid;
  assign result.repeat_length = out_len;

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= lcgrl_pkg::MULT_RESET;
      increment  <= lcgrl_pkg::INCR_RESET;
      modulus    <= lcgrl_pkg::MOD_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == lcgrl_pkg::REG_MULTIPLIER) begin
        multiplier <= cfg.data;
      end else if (cfg.index == lcgrl_pkg::REG_INCREMENT) begin
        increment <= cfg.data;
      end else if (cfg.index == lcgrl_pkg::REG_MODULUS) begin
        modulus <= cfg.data[lcgrl_pkg::MOD_W-1:0];
      end
    end
  end

  // Effective modulus: zero acts as one, saturate at the map depth
  always_comb begin
    if (modulus == '0) begin
      m_eff = (VW+1)'(1);
    end else if (32'(modulus) > 32'(MODULUS_MAX)) begin
      m_eff = (VW+1)'(MODULUS_MAX);
    end else begin
      m_eff = (VW+1)'(modulus);
    end
  end

  assign clr_last = (clr_cnt == VW'(MODULUS_MAX - 1));
  assign bit_last = (bit_cnt == BW'(OW - 1));
  assign out_free = !out_valid || result.ready;

  lcgrl_modstep #(
    .VW (VW)
  ) u_modstep (
    .acc    (acc),
    .addend (unit_addend),
    .m      (m_eff),
    .op     (unit_op),
    .res    (unit_res)
  );

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcgrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and unit/map controls
  always_comb begin
    state_next  = state;
    item.ready  = 1'b0;
    unit_op     = '0;
    unit_addend = c_red;
    map_we      = 1'b0;
    map_waddr   = acc;
    map_wdata   = 1'b1;
    unique case (state)
      lcgrl_pkg::ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) state_next = lcgrl_pkg::ST_CLEAR;
      end
      lcgrl_pkg::ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_cnt;
        map_wdata = 1'b0;
        if (clr_last) state_next = lcgrl_pkg::ST_RED_A;
      end
      lcgrl_pkg::ST_RED_A: begin
        unit_op     = '{dbl: 1'b1, add: opnd[OW-1]};
        unit_addend = VW'(1);
        if (bit_last) state_next = lcgrl_pkg::ST_RED_C;
      end
      lcgrl_pkg::ST_RED_C: begin
        unit_op     = '{dbl: 1'b1, add: opnd[OW-1]};
        unit_addend = VW'(1);
        if (bit_last) state_next = lcgrl_pkg::ST_MUL;
      end
      lcgrl_pkg::ST_MUL: begin
        unit_op     = '{dbl: 1'b1, add: opnd[OW-1]};
        unit_addend = a_red;
        if (bit_last) state_next = lcgrl_pkg::ST_ADD;
      end
      lcgrl_pkg::ST_ADD: begin
        unit_op     = '{dbl: 1'b0, add: 1'b1};
        unit_addend = c_red;
        state_next  = lcgrl_pkg::ST_CHECK;
      end
      lcgrl_pkg::ST_CHECK: begin
        if (map_rd) begin
          state_next = lcgrl_pkg::ST_FINISH;
        end else begin
          map_we     = 1'b1;
          state_next = lcgrl_pkg::ST_MUL;
        end
      end
      lcgrl_pkg::ST_FINISH: begin
        if (out_free) state_next = lcgrl_pkg::ST_IDLE;
      end
    endcase
  end

  // Advance the datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      lcgrl_pkg::ST_IDLE: begin
        if (item.valid) begin
          seed_reg <= item.seed;
          count    <= '0;
          clr_cnt  <= '0;
        end
      end
      lcgrl_pkg::ST_CLEAR: begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_last) begin
          acc     <= '0;
          opnd    <= OW'(multiplier);
          bit_cnt <= '0;
        end
      end
      lcgrl_pkg::ST_RED_A: begin
        acc     <= unit_res;
        opnd    <= opnd << 1;
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_last) begin
          a_red   <= unit_res;
          acc     <= '0;
          opnd    <= OW'(increment);
          bit_cnt <= '0;
        end
      end
      lcgrl_pkg::ST_RED_C: begin
        acc     <= unit_res;
        opnd    <= opnd << 1;
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_last) begin
          c_red   <= unit_res;
          acc     <= '0;
          opnd    <= OW'(seed_reg);
          bit_cnt <= '0;
        end
      end
      lcgrl_pkg::ST_MUL: begin
        acc     <= unit_res;
        opnd    <= opnd << 1;
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_last) bit_cnt <= '0;
      end
      lcgrl_pkg::ST_ADD: begin
        acc <= unit_res;
      end
      lcgrl_pkg::ST_CHECK: begin
        // Mark done by the map write; start the next product from zero
        if (!map_rd) begin
          count <= count + 1'b1;
          opnd  <= OW'(acc);
          acc   <= '0;
        end
      end
      lcgrl_pkg::ST_FINISH: begin
      end
    endcase
  end

  // Output register: load at finish, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lcgrl_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lcgrl_pkg::ST_FINISH && out_free) begin
      out_len <= LW'(count);
    end
  end

  // Visited map: one write port, one registered read at the new value
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    map_rd <= map_mem[unit_res];
  end

`ifndef SYNTHESIS
  a_accept_starts_clear: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> state == lcgrl_pkg::ST_CLEAR)
    else $error("accepted seed did not start the map clear");

  a_value_below_modulus: assert property (@(posedge clk) disable iff (rst)
    state == lcgrl_pkg::ST_CHECK |-> {1'b0, acc} < m_eff)
    else $error("generated value not below the modulus");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    state == lcgrl_pkg::ST_CHECK && !map_rd |-> 32'(count) < 32'(m_eff))
    else $error("distinct count reached the modulus with an unvisited value");

  a_finish_loads_output: assert property (@(posedge clk) disable iff (rst)
    state == lcgrl_pkg::ST_FINISH && out_free |=> out_valid)
    else $error("finished item did not reach the output register");
`endif

endmodule
